FILE: rtl/tpeq_pkg.sv
// Shared types, codes and default sizes for the three-level priority event queue.
package tpeq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int EVENT_WIDTH_DEFAULT = 32;
   localparam int NUM_LEVELS = 3;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_PRIO = 3'd1,
      ST_FULL     = 3'd2,
      ST_DISABLED = 3'd3,
      ST_EMPTY    = 3'd4
   } tpeq_status_type;

   typedef enum logic [1:0] {
      PRIO_LOW     = 2'd0,
      PRIO_NORMAL  = 2'd1,
      PRIO_HIGH    = 2'd2,
      PRIO_ILLEGAL = 2'd3
   } tpeq_prio_type;

   typedef enum logic {
      FUNC_PUSH = 1'b0,
      FUNC_TAKE = 1'b1
   } tpeq_func_type;

   typedef struct packed {
      logic push;
      logic pop;
   } tpeq_lvl_ctl_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } tpeq_lvl_stat_type;

endpackage

FILE: rtl/tpeq_cell.sv
// One queue entry cell that loads a pushed event or takes its neighbor's event on a pop.
module tpeq_cell #(
   parameter int EVENT_WIDTH = tpeq_pkg::EVENT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   load,
   input  logic                   shift,
   input  logic [EVENT_WIDTH-1:0] push_data,
   input  logic [EVENT_WIDTH-1:0] next_data,
   output logic [EVENT_WIDTH-1:0] data
);

   logic [EVENT_WIDTH-1:0] data_ff;
   logic [EVENT_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      priority if (load) begin
         data_in = push_data;
      end else if (shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

FILE: rtl/tpeq_level.sv
// One priority level: a chain of entry cells with the head at cell zero and an entry count.
module tpeq_level #(
   parameter int QUEUE_DEPTH = tpeq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int EVENT_WIDTH = tpeq_pkg::EVENT_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tpeq_pkg::tpeq_lvl_ctl_type  ctl,
   input  logic [EVENT_WIDTH-1:0]      push_data,
   output tpeq_pkg::tpeq_lvl_stat_type stat,
   output logic [EVENT_WIDTH-1:0]      head_data
);

   import tpeq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [EVENT_WIDTH-1:0] cell_data [QUEUE_DEPTH];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [EVENT_WIDTH-1:0] next_data;
      logic                   load;

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_data = cell_data[i];
      end else begin : g_mid
         assign next_data = cell_data[i+1];
      end

      assign load = ctl.push && (count_ff == CNT_W'(i));

      tpeq_cell #(
         .EVENT_WIDTH(EVENT_WIDTH)
      ) u_cell (
         .clock    (clock),
         .load     (load),
         .shift    (ctl.pop),
         .push_data(push_data),
         .next_data(next_data),
         .data     (cell_data[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      priority if (ctl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.nonempty = (count_ff != '0);
   assign head_data     = cell_data[0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count exceeds queue depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> !stat.full)
      else $error("push into a full level");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> stat.nonempty)
      else $error("pop from an empty level");

endmodule

FILE: rtl/three_level_priority_event_queue.sv
// Top level of the three-level strict-priority event queue.
// A beat is accepted when start is high and busy is low, and its result appears on the rsp_
// ports with rsp_strobe high in the next cycle, so a new command may be issued every cycle
// while busy is low. That rate is set by the cell chains, which shift or load all entries of a
// level at once. busy is high during reset and in the first cycle after reset; there is no
// clearing pass. Takes are served from the high, then normal, then low level, and
// the enable register gates pushes only. Results cannot be held off by the receiver.
module three_level_priority_event_queue #(
   parameter int QUEUE_DEPTH = tpeq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int EVENT_WIDTH = tpeq_pkg::EVENT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_func,
   input  logic [1:0]             req_priority_req,
   input  logic [EVENT_WIDTH-1:0] req_event_data,
   output logic                   rsp_strobe,
   output logic [2:0]             rsp_status,
   output logic                   rsp_event_valid,
   output logic [EVENT_WIDTH-1:0] rsp_event_out,
   output logic [1:0]             rsp_served_priority,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_enabled
);

   import tpeq_pkg::*;

   logic busy_ff;
   logic enabled_ff;
   logic accept;

   tpeq_lvl_ctl_type       ctl  [NUM_LEVELS];
   tpeq_lvl_stat_type      stat [NUM_LEVELS];
   logic [EVENT_WIDTH-1:0] head [NUM_LEVELS];

   logic                   strobe_ff;
   tpeq_status_type        status_ff;
   tpeq_status_type        status_in;
   logic                   valid_ff;
   logic                   valid_in;
   logic [EVENT_WIDTH-1:0] event_ff;
   logic [EVENT_WIDTH-1:0] event_in;
   tpeq_prio_type          served_ff;
   tpeq_prio_type          served_in;

   for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_level
      tpeq_level #(
         .QUEUE_DEPTH(QUEUE_DEPTH),
         .EVENT_WIDTH(EVENT_WIDTH)
      ) u_level (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl[l]),
         .push_data(req_event_data),
         .stat     (stat[l]),
         .head_data(head[l])
      );
   end

   assign accept = start && !busy_ff;

   always_comb begin
      status_in = ST_OK;
      valid_in  = 1'b0;
      event_in  = '0;
      served_in = PRIO_LOW;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         ctl[l] = '0;
      end
      if (accept) begin
         if (req_func == FUNC_PUSH) begin
            priority if (!enabled_ff) begin
               status_in = ST_DISABLED;
            end else if (req_priority_req == PRIO_ILLEGAL) begin
               status_in = ST_BAD_PRIO;
            end else if (stat[req_priority_req].full) begin
               status_in = ST_FULL;
            end else begin
               ctl[req_priority_req].push = 1'b1;
            end
         end else begin
            priority if (stat[PRIO_HIGH].nonempty) begin
               served_in = PRIO_HIGH;
            end else if (stat[PRIO_NORMAL].nonempty) begin
               served_in = PRIO_NORMAL;
            end else if (stat[PRIO_LOW].nonempty) begin
               served_in = PRIO_LOW;
            end else begin
               status_in = ST_EMPTY;
            end
            if (status_in == ST_OK) begin
               ctl[served_in].pop = 1'b1;
               valid_in = 1'b1;
               event_in = head[served_in];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         enabled_ff <= 1'b1;
         strobe_ff  <= 1'b0;
      end else begin
         busy_ff   <= 1'b0;
         strobe_ff <= accept;
         if (csr_valid && csr_ready) begin
            enabled_ff <= csr_enabled;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      valid_ff  <= valid_in;
      event_ff  <= event_in;
      served_ff <= served_in;
   end

   assign busy                = busy_ff;
   assign csr_ready           = !busy_ff;
   assign rsp_strobe          = strobe_ff;
   assign rsp_status          = status_ff;
   assign rsp_event_valid     = valid_ff;
   assign rsp_event_out       = event_ff;
   assign rsp_served_priority = served_ff;

   a_one_update: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl[0].push, ctl[1].push, ctl[2].push, ctl[0].pop, ctl[1].pop, ctl[2].pop}))
      else $error("more than one level updated in a cycle");

   a_strobe_follows_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy))
      else $error("result strobe without an accepted beat");

   a_valid_means_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_event_valid) |->
         (rsp_status == ST_OK && rsp_served_priority != PRIO_ILLEGAL))
      else $error("event returned with a failing status");

endmodule
